// ===== rtl/lcg_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants for the ranged random core
// Holds the generator constants, the job word passed from the front end to
// the back end, and the letter lookup.
// ----------------------------------------------------------------------------
package lcg_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] LCG_MUL      = 32'd1664525;
    localparam logic [WORD_W-1:0] LCG_INC      = 32'd1013904223;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd1;

    // State modulo 52 is four times (state >> 2) modulo 13 plus the two low
    // bits; the quotient by 13 of a 30-bit value is exact with ceil(2^34 / 13)
    localparam logic [30:0]       LETTER_RECIP = 31'd1321528399;
    localparam int unsigned       LETTER_SHIFT = 34;

    localparam int unsigned LETTER_IDX_W = 6;
    localparam int unsigned ALPHA_LEN    = 26;

    // What the back end has to do with a job
    typedef enum logic [1:0] {
        JOB_RANGE  = 2'd0,  // low plus state modulo span
        JOB_LETTER = 2'd1,  // letter picked by state modulo 52
        JOB_BAD    = 2'd2,  // reversed range: report low and flag
        JOB_FULL   = 2'd3   // whole 32-bit span: low plus state
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [WORD_W-1:0] state;
        logic [WORD_W-1:0] low;
        logic [WORD_W-1:0] span;
    } job_t;

    // Map 0..51 to A..Z then a..z
    function automatic logic [7:0] letter_code(input logic [LETTER_IDX_W-1:0] idx);
        logic [7:0] code;
        if (idx < LETTER_IDX_W'(ALPHA_LEN))
        begin
            code = 8'h41 + {2'b00, idx};
        end
        else
        begin
            code = 8'h61 + {2'b00, idx} - 8'(ALPHA_LEN);
        end
        return code;
    endfunction

endpackage

// ===== rtl/lcg_front.sv =====
// ----------------------------------------------------------------------------
// lcg_front: request intake and generator state
// Accepts a request word, advances the generator, classifies the request
// and pushes a job word into the queue.
// ----------------------------------------------------------------------------
module lcg_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_we,
    input  logic [lcg_pkg::WORD_W-1:0]  seed_wdata,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic                        req_type,
    input  logic [lcg_pkg::WORD_W-1:0]  range_low,
    input  logic [lcg_pkg::WORD_W-1:0]  range_high,
    input  logic                        q_full,
    output logic                        q_push,
    output lcg_pkg::job_t               q_job
);

    logic [lcg_pkg::WORD_W-1:0] seed_reg;
    logic [lcg_pkg::WORD_W-1:0] state_reg;
    logic [lcg_pkg::WORD_W-1:0] state_next;
    logic [lcg_pkg::WORD_W-1:0] base;
    logic [lcg_pkg::WORD_W-1:0] product;
    logic [lcg_pkg::WORD_W-1:0] span;
    logic                       reversed;

    assign req_ready = !q_full;
    assign q_push    = req_valid && !q_full;

    // Reload from the seed whenever the state sits at zero, then step
    assign base       = (state_reg == '0) ? seed_reg : state_reg;
    assign product    = base * lcg_pkg::LCG_MUL;
    assign state_next = product + lcg_pkg::LCG_INC;

    // Classify the request
    assign reversed = $signed(range_high) < $signed(range_low);
    assign span     = range_high - range_low + lcg_pkg::WORD_W'(1);

    always_comb
    begin
        q_job.state = state_next;
        q_job.low   = range_low;
        q_job.span  = span;
        if (req_type)
        begin
            q_job.kind = lcg_pkg::JOB_LETTER;
        end
        else if (reversed)
        begin
            q_job.kind = lcg_pkg::JOB_BAD;
        end
        else if (span == '0)
        begin
            q_job.kind = lcg_pkg::JOB_FULL;
        end
        else
        begin
            q_job.kind = lcg_pkg::JOB_RANGE;
        end
    end

    // Hold seed and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= lcg_pkg::SEED_RESET;
            state_reg <= '0;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
            if (q_push)
            begin
                state_reg <= state_next;
            end
        end
    end

endmodule

// ===== rtl/lcg_queue.sv =====
// ----------------------------------------------------------------------------
// lcg_queue: job queue between front and back end
// Small register queue of job words; push and pop may happen together.
// ----------------------------------------------------------------------------
module lcg_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lcg_pkg::job_t push_job,
    input  logic          pop,
    output lcg_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lcg_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    // Store pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/lcg_back.sv =====
// ----------------------------------------------------------------------------
// lcg_back: job execution and result register
// Takes a job from the queue, reduces the state by the span with a
// one-bit-per-cycle restoring remainder or by 52 with a reciprocal multiply,
// and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module lcg_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  lcg_pkg::job_t               q_job,
    output logic                        q_pop,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [lcg_pkg::WORD_W-1:0]  res_value,
    output logic                        res_bad
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_LETTER,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [lcg_pkg::WORD_W-1:0]    low_reg;
    logic [lcg_pkg::WORD_W-1:0]    divisor_reg;
    logic [lcg_pkg::WORD_W-1:0]    dividend_reg;
    logic [lcg_pkg::WORD_W-1:0]    rem_reg;
    logic [lcg_pkg::STEP_W-1:0]    step_reg;
    logic [lcg_pkg::WORD_W-1:0]    value_reg;
    logic                          bad_reg;
    logic [26:0]                   quot_reg;

    logic [lcg_pkg::WORD_W:0]      shifted;
    logic [lcg_pkg::WORD_W+1:0]    diff;
    logic [lcg_pkg::WORD_W-1:0]    rem_new;
    logic [60:0]                   recip_prod;
    logic [29:0]                   quot_x13;
    logic [29:0]                   rem13_full;

    assign res_valid = (state_reg == ST_DONE);
    assign res_value = value_reg;
    assign res_bad   = bad_reg;

    // Take the next job when idle or when the held word leaves this cycle
    assign q_pop = !q_empty && ((state_reg == ST_IDLE) || (state_reg == ST_DONE && res_ready));

    // One restoring remainder step
    assign shifted = {rem_reg, dividend_reg[lcg_pkg::WORD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};
    assign rem_new = diff[lcg_pkg::WORD_W+1] ? shifted[lcg_pkg::WORD_W-1:0]
                                              : diff[lcg_pkg::WORD_W-1:0];

    // Quotient of (state >> 2) by 13, then the remainder by shift and add
    assign recip_prod = 61'(q_job.state[31:2]) * 61'(lcg_pkg::LETTER_RECIP);
    assign quot_x13   = {quot_reg, 3'b000} + {1'b0, quot_reg, 2'b00} + {3'b000, quot_reg};
    assign rem13_full = dividend_reg[31:2] - quot_x13;

    // Hold state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            low_reg      <= '0;
            divisor_reg  <= '0;
            dividend_reg <= '0;
            rem_reg      <= '0;
            step_reg     <= '0;
            value_reg    <= '0;
            bad_reg      <= 1'b0;
            quot_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE, ST_DONE:
                begin
                    if (q_pop)
                    begin
                        low_reg      <= q_job.low;
                        dividend_reg <= q_job.state;
                        rem_reg      <= '0;
                        step_reg     <= lcg_pkg::STEP_W'(lcg_pkg::DIV_STEPS - 1);
                        bad_reg      <= 1'b0;
                        unique case (q_job.kind)
                            lcg_pkg::JOB_BAD:
                            begin
                                value_reg <= q_job.low;
                                bad_reg   <= 1'b1;
                                state_reg <= ST_DONE;
                            end
                            lcg_pkg::JOB_FULL:
                            begin
                                value_reg <= q_job.low + q_job.state;
                                state_reg <= ST_DONE;
                            end
                            lcg_pkg::JOB_LETTER:
                            begin
                                quot_reg  <= recip_prod[lcg_pkg::LETTER_SHIFT +: 27];
                                state_reg <= ST_LETTER;
                            end
                            lcg_pkg::JOB_RANGE:
                            begin
                                divisor_reg <= q_job.span;
                                state_reg   <= ST_DIV;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                    else if (state_reg == ST_DONE && res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    rem_reg      <= rem_new;
                    dividend_reg <= {dividend_reg[lcg_pkg::WORD_W-2:0], 1'b0};
                    step_reg     <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        // Form the result from the final remainder
                        value_reg <= low_reg + rem_new;
                        state_reg <= ST_DONE;
                    end
                end
                ST_LETTER:
                begin
                    // Letter index is four times the remainder by 13 plus the low bits
                    value_reg <= {24'd0,
                        lcg_pkg::letter_code({rem13_full[3:0], dividend_reg[1:0]})};
                    state_reg <= ST_DONE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/lcg_ranged_random_core.sv =====
// ----------------------------------------------------------------------------
// lcg_ranged_random_core: 32-bit LCG random source with range and letter modes
// Front end advances the generator, a job queue decouples it from the back
// end, which reduces the state and delivers one result word per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis: tuser[0] selects letter mode (1) or range mode
//   (0); tdata carries range_low and range_high. Each request yields exactly
//   one result word on m_axis: tdata is the value, tuser[0] the bad range
//   flag. seed_we/seed_wdata write the seed loaded whenever the state is 0.
//   Path from request to result word: range mode goes through the queue,
//   then 32 serial remainder steps at one bit per cycle; letter mode goes
//   through the queue, a reciprocal multiply, then the remainder by 13 and
//   the letter lookup; reversed ranges and full 32-bit spans go through the
//   queue only. The back end starts no new job until its result word is
//   taken; the queue keeps taking requests meanwhile until it is full.
//   Reset: generator state clears to 0 and the seed to 1; queue empty.
//   Stall: a held result stays on m_axis; the back end waits, the queue
//   fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module lcg_ranged_random_core
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] range_low, [63:32] range_high
    input  logic [0:0]  s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [0:0]  m_axis_tuser    // [0] bad_range
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    lcg_pkg::job_t push_job;
    lcg_pkg::job_t head_job;

    // Intake and generator
    lcg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_type   (s_axis_tuser[0]),
        .range_low  (s_axis_tdata[31:0]),
        .range_high (s_axis_tdata[63:32]),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    // Job queue
    lcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Remainder and result register
    lcg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_value (m_axis_tdata),
        .res_bad   (m_axis_tuser[0])
    );

endmodule
